FILE: sv/dbp_pkg.sv
// Package for the delta/run bit packer: code prefixes, class limits and
// the encoder-to-output-buffer result type. No dependencies.
`timescale 1ns / 1ps

package dbp_pkg;

    // Magnitude limits of the four difference classes
    localparam logic [7:0] CLASS_LIMIT [4] = '{8'd2, 8'd6, 8'd14, 8'd30};

    // Two-bit code prefixes
    localparam logic [1:0] DIFF_PREFIX = 2'b00;
    localparam logic [1:0] RUN_PREFIX  = 2'b01;
    localparam logic [1:0] ABS_PREFIX  = 2'b10;
    localparam logic [1:0] END_CODE    = 2'b11;

    // Longest run held before a run code goes out (8 - 1)
    localparam logic [2:0] RUN_FULL = 3'd7;

    // Bit window built per sample: up to 7 held + 5 + 11 + 2 bits
    localparam int ACC_W = 32;

    typedef struct packed {
        logic [ACC_W-1:0] bytes;   // finished bytes, earliest in the top byte
        logic [2:0]       count;   // number of finished bytes (0..4)
        logic             last;    // block ends with the final byte
    } t_enc_result;

endpackage

FILE: sv/dbp_ifs.sv
// Valid/ready channel interfaces for sample input and packed byte output.
// No dependencies.
`timescale 1ns / 1ps

interface dbp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] sample;
    logic       final_sample;

    modport source (output valid, output sample, output final_sample, input ready);
    modport sink   (input valid, input sample, input final_sample, output ready);
endinterface

interface dbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: sv/delta_run_bit_packer_core.sv
// Delta / zero-run / variable-length bit packer, top level.
// Path: input stage register, combinational encoder, result register.
// Throughput: one sample per cycle while each sample finishes at most one
// byte and output is ready; extra bytes hold the encoder until they drain.
// Reset: synchronous active-low i_rst_n empties both stages and restarts
// the block, so the next sample goes out raw.
`timescale 1ns / 1ps

module delta_run_bit_packer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dbp_in_if.sink    i_in,
    dbp_out_if.source o_out
);
    import dbp_pkg::*;

    // Input stage: one sample word held for the encoder
    logic       r_in_valid;
    logic [7:0] r_sample;
    logic       r_final;

    logic        fire;
    logic        can_load;
    t_enc_result enc_result;

    // Encoder consumes the held word once the output buffer can take
    // its bytes (empty, or draining its last byte this cycle).
    assign fire       = r_in_valid && can_load;
    assign i_in.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.valid && i_in.ready) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_sample <= i_in.sample;
            r_final  <= i_in.final_sample;
        end
    end

    // Coding, bit merge and byte split in one pass
    dbp_encoder u_encoder (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_sample (r_sample),
        .i_final  (r_final),
        .o_result (enc_result)
    );

    // Result register: finished bytes leave one word per cycle while ready is high
    dbp_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_result   (enc_result),
        .i_ready    (o_out.ready),
        .o_valid    (o_out.valid),
        .o_byte     (o_out.out_byte),
        .o_last     (o_out.out_last),
        .o_can_load (can_load)
    );

endmodule

FILE: sv/dbp_encoder.sv
// Encoder: codes one registered sample into bits, merges them with the
// partial byte and returns finished bytes. Depends on dbp_pkg.
`timescale 1ns / 1ps

module dbp_encoder (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  logic [7:0]           i_sample,
    input  logic                 i_final,
    output dbp_pkg::t_enc_result o_result
);
    import dbp_pkg::*;

    logic [7:0] r_prev,  n_prev;
    logic       r_first, n_first;
    logic [2:0] r_run,   n_run;
    logic [7:0] r_pack,  n_pack;
    logic [2:0] r_fill,  n_fill;

    logic        neg, is_zero, big;
    logic [7:0]  mag;
    logic [1:0]  cls;
    logic [2:0]  nbits;
    logic [5:0]  code6;
    logic [4:0]  code5;
    logic        a_en;
    logic [4:0]  a_seg;
    logic [10:0] b_seg;
    logic [3:0]  b_len;
    logic [1:0]  c_seg;
    logic [4:0]  pos_b, pos_c, total;
    logic [5:0]  total_rnd;
    logic [ACC_W-1:0] acc;

    always_comb begin
        neg     = i_sample < r_prev;
        is_zero = i_sample == r_prev;
        mag     = neg ? (r_prev - i_sample) : (i_sample - r_prev);
        big     = mag > CLASS_LIMIT[3];

        if (mag <= CLASS_LIMIT[0]) begin
            cls = 2'd0;
        end else if (mag <= CLASS_LIMIT[1]) begin
            cls = 2'd1;
        end else if (mag <= CLASS_LIMIT[2]) begin
            cls = 2'd2;
        end else begin
            cls = 2'd3;
        end
        nbits = {1'b0, cls} + 3'd2;

        // negative: 2^n - 2 - |d|, positive: |d| + 1
        code6 = neg ? ((6'd1 << nbits) - 6'd2 - mag[5:0]) : (mag[5:0] + 6'd1);
        code5 = code6[4:0] << (2'd3 - cls);

        // run code: held run ends or fills up
        a_en  = !r_first && ((is_zero && (r_run == RUN_FULL || i_final)) ||
                             (!is_zero && r_run != 3'd0));
        a_seg = a_en ? {RUN_PREFIX, (is_zero ? r_run : r_run - 3'd1)} : 5'd0;

        // raw byte, difference code, absolute code or nothing
        if (r_first) begin
            b_seg = {i_sample, 3'b000};
            b_len = 4'd8;
        end else if (is_zero) begin
            b_seg = 11'd0;
            b_len = 4'd0;
        end else if (big) begin
            b_seg = {ABS_PREFIX, neg, mag};
            b_len = 4'd11;
        end else begin
            b_seg = {DIFF_PREFIX, cls, code5, 2'b00};
            b_len = {2'b00, cls} + 4'd6;
        end

        c_seg = i_final ? END_CODE : 2'b00;

        pos_b = {2'b00, r_fill} + (a_en ? 5'd5 : 5'd0);
        pos_c = pos_b + {1'b0, b_len};
        total = pos_c + (i_final ? 5'd2 : 5'd0);

        acc = {r_pack, 24'd0}
            | ({a_seg, 27'd0} >> r_fill)
            | ({b_seg, 21'd0} >> pos_b)
            | ({c_seg, 30'd0} >> pos_c);

        total_rnd = {1'b0, total} + 6'd7;

        o_result.bytes = acc;
        o_result.count = i_final ? total_rnd[5:3] : {1'b0, total[4:3]};
        o_result.last  = i_final;

        case (total[4:3])
            2'd0:    n_pack = acc[31:24];
            2'd1:    n_pack = acc[23:16];
            2'd2:    n_pack = acc[15:8];
            default: n_pack = acc[7:0];
        endcase
        n_fill  = total[2:0];
        n_prev  = i_sample;
        n_first = 1'b0;
        if (r_first || !is_zero || a_en) begin
            n_run = 3'd0;
        end else begin
            n_run = r_run + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 8'd0;
            r_first <= 1'b1;
            r_run   <= 3'd0;
            r_pack  <= 8'd0;
            r_fill  <= 3'd0;
        end else if (i_fire) begin
            if (i_final) begin
                r_prev  <= 8'd0;
                r_first <= 1'b1;
                r_run   <= 3'd0;
                r_pack  <= 8'd0;
                r_fill  <= 3'd0;
            end else begin
                r_prev  <= n_prev;
                r_first <= n_first;
                r_run   <= n_run;
                r_pack  <= n_pack;
                r_fill  <= n_fill;
            end
        end
    end

endmodule

FILE: sv/dbp_out_buf.sv
// Output buffer: holds up to four finished bytes and shifts them out one
// word per handshake. Depends on dbp_pkg.
`timescale 1ns / 1ps

module dbp_out_buf (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  dbp_pkg::t_enc_result i_result,
    input  logic                 i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_byte,
    output logic                 o_last,
    output logic                 o_can_load
);
    import dbp_pkg::*;

    logic [ACC_W-1:0] r_buf;
    logic [2:0]       r_cnt;
    logic             r_last;
    logic             pop;

    assign o_valid    = r_cnt != 3'd0;
    assign o_byte     = r_buf[ACC_W-1 -: 8];
    assign o_last     = r_last && r_cnt == 3'd1;
    assign pop        = o_valid && i_ready;
    assign o_can_load = r_cnt == 3'd0 || (r_cnt == 3'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            r_last <= 1'b0;
        end else if (i_load) begin
            r_cnt  <= i_result.count;
            r_last <= i_result.last;
        end else if (pop) begin
            r_cnt  <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_buf <= i_result.bytes;
        end else if (pop) begin
            r_buf <= {r_buf[ACC_W-9:0], 8'd0};
        end
    end

endmodule

FILE: sv/dbp_checker.sv
// Port-level checks for delta_run_bit_packer_core, bound to the top level.
// Depends on the top level's channel interfaces.
`timescale 1ns / 1ps

module dbp_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_final,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // Input only backs up behind a pending output word
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output pending");

    // End of block always yields a byte
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_in_final) |-> ##2 i_out_valid)
        else $error("final sample produced no output");

    // Reset empties the output side
    assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // Stalled output word holds
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_byte) && $stable(i_out_last)))
        else $error("stalled output word changed");

endmodule

bind delta_run_bit_packer_core dbp_checker u_dbp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_final  (i_in.final_sample),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_last  (o_out.out_last)
);
